>>> design/least_loaded_machine_dispatch_defines.svh
// Assertion macros for the least-loaded machine dispatch block.
// Used by the top level only; the macros expect clk_i and rst_ni in scope.
`ifndef LEAST_LOADED_MACHINE_DISPATCH_DEFINES_SVH
`define LEAST_LOADED_MACHINE_DISPATCH_DEFINES_SVH

`define LLMD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("llmd assertion failed");

`define LLMD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("llmd assertion failed");

`endif

>>> design/llmd_pkg.sv
// Package for the least-loaded machine dispatch block: sizes, payload structs
// and the command and status structs between controller and datapath. No dependencies.
`default_nettype none

package llmd_pkg;

  localparam int MAX_MACHINES = 16;
  localparam int LOAD_BITS    = 32;
  localparam int IDX_W        = $clog2(MAX_MACHINES);
  localparam int CNT_W        = 5;
  localparam int WEIGHT_W     = 16;
  localparam int OUT_IDX_W    = 4;
  localparam int OUT_LOAD_W   = 32;

  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(16);

  typedef struct packed {
    logic                first_job;
    logic [WEIGHT_W-1:0] job_weight;
  } llmd_in_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0]  chosen_machine;
    logic [OUT_LOAD_W-1:0] machine_load;
    logic [OUT_LOAD_W-1:0] makespan;
  } llmd_out_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic write;
  } llmd_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } llmd_status_t;

endpackage

`default_nettype wire

>>> design/llmd_ctrl.sv
// Controller state machine of the least-loaded machine dispatch block.
// Depends on llmd_pkg; drives commands to llmd_datapath and reads its status.
`default_nettype none

module llmd_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire llmd_pkg::llmd_status_t status_i,
  output llmd_pkg::llmd_cmd_t        cmd_o
);
  import llmd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_WRITE = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (status_i.out_free) begin
          cmd_o.write = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> design/llmd_datapath.sv
// Datapath of the least-loaded machine dispatch block: load store, scan,
// saturating add, makespan and output register. Depends on llmd_pkg.
`default_nettype none

module llmd_datapath (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire llmd_pkg::llmd_in_t         in_data_i,
  input  wire logic                       cfg_write_i,
  input  wire logic [llmd_pkg::CNT_W-1:0] cfg_data_i,
  input  wire llmd_pkg::llmd_cmd_t        cmd_i,
  output llmd_pkg::llmd_status_t          status_o,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output llmd_pkg::llmd_out_t             out_data_o
);
  import llmd_pkg::*;

  logic [LOAD_BITS-1:0]    loads_q [MAX_MACHINES];
  logic [MAX_MACHINES-1:0] valid_q;
  logic [LOAD_BITS-1:0]    makespan_q;
  logic [CNT_W-1:0]        count_q;
  logic [WEIGHT_W-1:0]     weight_q;
  logic [IDX_W-1:0]        idx_q;
  logic [IDX_W-1:0]        best_idx_q;
  logic [LOAD_BITS-1:0]    best_load_q;
  logic                    out_valid_q;
  llmd_out_t               out_q;

  logic [IDX_W-1:0]     last_idx;
  logic [LOAD_BITS-1:0] rd_load;
  logic [LOAD_BITS:0]   sum;
  logic [LOAD_BITS-1:0] new_load;
  logic [LOAD_BITS-1:0] new_makespan;

  always_comb begin
    if (count_q == '0) begin
      last_idx = '0;
    end else if (count_q >= CNT_W'(MAX_MACHINES)) begin
      last_idx = IDX_W'(MAX_MACHINES - 1);
    end else begin
      last_idx = IDX_W'(count_q - CNT_W'(1));
    end
  end

  assign rd_load      = valid_q[idx_q] ? loads_q[idx_q] : '0;
  assign sum          = {1'b0, best_load_q} + (LOAD_BITS + 1)'(weight_q);
  assign new_load     = sum[LOAD_BITS] ? {LOAD_BITS{1'b1}} : sum[LOAD_BITS-1:0];
  assign new_makespan = (new_load > makespan_q) ? new_load : makespan_q;

  assign status_o.scan_last = (idx_q == last_idx);
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      makespan_q  <= '0;
      count_q     <= COUNT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_write_i) begin
        count_q <= cfg_data_i;
      end
      if (cmd_i.start && in_data_i.first_job) begin
        valid_q    <= '0;
        makespan_q <= '0;
      end else if (cmd_i.write) begin
        valid_q[best_idx_q] <= 1'b1;
        makespan_q          <= new_makespan;
      end
      if (cmd_i.write) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      weight_q <= in_data_i.job_weight;
      idx_q    <= '0;
    end
    if (cmd_i.scan) begin
      if (idx_q == '0 || rd_load < best_load_q) begin
        best_idx_q  <= idx_q;
        best_load_q <= rd_load;
      end
      idx_q <= idx_q + IDX_W'(1);
    end
    if (cmd_i.write) begin
      loads_q[best_idx_q]  <= new_load;
      out_q.chosen_machine <= OUT_IDX_W'(best_idx_q);
      out_q.machine_load   <= OUT_LOAD_W'(new_load);
      out_q.makespan       <= OUT_LOAD_W'(new_makespan);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> design/least_loaded_machine_dispatch.sv
// Top level of the least-loaded machine dispatch block (greedy list scheduling).
// Depends on llmd_pkg, llmd_ctrl, llmd_datapath and the assertion macro header.
//
// Usage: jobs enter on the in channel (in_valid_i, in_stall_o, in_data_i) and
// each yields one result item on the out channel (out_valid_o, out_stall_i,
// out_data_o). The machine count register is written on the cfg channel
// (cfg_valid_i, cfg_ready_o, cfg_data_i); write it only while the block is idle.
// An accepted item is scanned one machine load per cycle over the active
// machines, then placed and its result written to the output register.
// The next item is accepted in the cycle after placement, so the block takes
// no new item before the last one is placed.
// The output register holds a finished result while the receiver stalls and
// the next item is accepted and scanned meanwhile; placement waits only while
// the earlier result is still held.
// Reset clears all loads, the makespan and both valids, and sets the machine
// count to 16.
`default_nettype none
`include "least_loaded_machine_dispatch_defines.svh"

module least_loaded_machine_dispatch (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire llmd_pkg::llmd_in_t         in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output llmd_pkg::llmd_out_t             out_data_o,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [llmd_pkg::CNT_W-1:0] cfg_data_i
);
  import llmd_pkg::*;

  llmd_cmd_t    cmd;
  llmd_status_t status;

  assign cfg_ready_o = 1'b1;

  llmd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  llmd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_write_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  `LLMD_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `LLMD_ASSERT_SAME(a_load_within_makespan, out_valid_o, out_data_o.machine_load <= out_data_o.makespan)
  `LLMD_ASSERT_SAME(a_result_frees_input, $rose(out_valid_o), !in_stall_o)

endmodule

`default_nettype wire
